### rtl/core/ptrs_pkg.sv
// ============================================================================
// ptrs_pkg: periodic task release scheduler shared definitions
// Sizes, command codes, internal op and state encodings, queue entry types.
// ============================================================================
package ptrs_pkg;

    localparam int MAX_TASKS = 8;
    localparam int SLOT_W    = $clog2(MAX_TASKS);

    localparam int CMD_W  = 2;
    localparam int TASK_W = 3;
    localparam int TIME_W = 32;
    localparam int PEND_W = 16;

    localparam logic [TIME_W-1:0] FP_PRIO_LIMIT = TIME_W'(100);
    localparam logic [PEND_W-1:0] PENDING_MAX   = '1;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_WRITE  = CMD_W'(0);
    localparam logic [CMD_W-1:0] CMD_TICK   = CMD_W'(1);
    localparam logic [CMD_W-1:0] CMD_SELECT = CMD_W'(2);

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_TICK,
        OP_SELECT,
        OP_NOP
    } ptrs_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ptrs_state_t;

    typedef struct packed {
        ptrs_op_t            op;
        logic [TASK_W-1:0]   task_index;
        logic                entry_valid;
        logic [TIME_W-1:0]   entry_period;
        logic [TIME_W-1:0]   entry_release_time;
        logic                entry_is_edf;
        logic [TIME_W-1:0]   entry_priority;
        logic [PEND_W-1:0]   entry_pending;
        logic [TIME_W-1:0]   now_time;
        logic [TASK_W-1:0]   current_task;
    } ptrs_cmd_t;

    typedef struct packed {
        logic      valid;
        ptrs_cmd_t cmd;
    } ptrs_qhead_t;

endpackage

### rtl/core/ptrs_if.sv
// ============================================================================
// ptrs_if: scheduler channel interfaces
// Command channel and result channel, valid/ready handshake.
// ============================================================================
interface ptrs_in_if;
    logic                          valid;
    logic                          ready;
    logic [ptrs_pkg::CMD_W-1:0]    command;
    logic [ptrs_pkg::TASK_W-1:0]   task_index;
    logic                          entry_valid;
    logic [ptrs_pkg::TIME_W-1:0]   entry_period;
    logic [ptrs_pkg::TIME_W-1:0]   entry_release_time;
    logic                          entry_is_edf;
    logic [ptrs_pkg::TIME_W-1:0]   entry_priority;
    logic [ptrs_pkg::PEND_W-1:0]   entry_pending;
    logic [ptrs_pkg::TIME_W-1:0]   now_time;
    logic [ptrs_pkg::TASK_W-1:0]   current_task;

    modport source (
        output valid, command, task_index, entry_valid, entry_period,
               entry_release_time, entry_is_edf, entry_priority, entry_pending,
               now_time, current_task,
        input  ready
    );
    modport sink (
        input  valid, command, task_index, entry_valid, entry_period,
               entry_release_time, entry_is_edf, entry_priority, entry_pending,
               now_time, current_task,
        output ready
    );
endinterface

interface ptrs_out_if;
    logic                          valid;
    logic                          ready;
    logic [ptrs_pkg::TASK_W-1:0]   best_task;
    logic                          switch_needed;
    logic                          released_any;
    logic [ptrs_pkg::TIME_W-1:0]   release_total;

    modport source (
        output valid, best_task, switch_needed, released_any, release_total,
        input  ready
    );
    modport sink (
        input  valid, best_task, switch_needed, released_any, release_total,
        output ready
    );
endinterface

### rtl/core/ptrs_front.sv
// ============================================================================
// ptrs_front: command intake
// Accepts command beats, decodes them into ops and holds them in a short queue.
// ============================================================================
module ptrs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    ptrs_in_if.sink              task_cmd,
    output ptrs_pkg::ptrs_qhead_t qhead,
    input  logic                 pop
);
    import ptrs_pkg::*;

    ptrs_cmd_t           q_mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    ptrs_cmd_t           dec_cmd;
    logic                push;

    // decode: out-of-range writes and the spare code become no-ops
    always_comb
    begin
        dec_cmd.task_index         = task_cmd.task_index;
        dec_cmd.entry_valid        = task_cmd.entry_valid;
        dec_cmd.entry_period       = task_cmd.entry_period;
        dec_cmd.entry_release_time = task_cmd.entry_release_time;
        dec_cmd.entry_is_edf       = task_cmd.entry_is_edf;
        dec_cmd.entry_priority     = task_cmd.entry_priority;
        dec_cmd.entry_pending      = task_cmd.entry_pending;
        dec_cmd.now_time           = task_cmd.now_time;
        dec_cmd.current_task       = task_cmd.current_task;
        case (task_cmd.command)
            CMD_WRITE:
            begin
                if (32'(task_cmd.task_index) < 32'(MAX_TASKS))
                    dec_cmd.op = OP_WRITE;
                else
                    dec_cmd.op = OP_NOP;
            end
            CMD_TICK:   dec_cmd.op = OP_TICK;
            CMD_SELECT: dec_cmd.op = OP_SELECT;
            default:    dec_cmd.op = OP_NOP;
        endcase
    end

    assign task_cmd.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push           = task_cmd.valid && task_cmd.ready;

    assign qhead.valid = (count_reg != '0);
    assign qhead.cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= dec_cmd;
    end

endmodule

### rtl/core/ptrs_back.sv
// ============================================================================
// ptrs_back: task table and scan engine
// Executes queued ops: table writes, release scans, best-task scans.
// ============================================================================
module ptrs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptrs_pkg::ptrs_qhead_t qhead,
    output logic                  pop,
    ptrs_out_if.source            sched_res
);
    import ptrs_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);

    logic                slot_valid_reg   [MAX_TASKS];
    logic [TIME_W-1:0]   slot_period_reg  [MAX_TASKS];
    logic [TIME_W-1:0]   slot_release_reg [MAX_TASKS];
    logic                slot_edf_reg     [MAX_TASKS];
    logic [TIME_W-1:0]   slot_prio_reg    [MAX_TASKS];
    logic [PEND_W-1:0]   slot_pend_reg    [MAX_TASKS];
    logic                slot_valid_next   [MAX_TASKS];
    logic [TIME_W-1:0]   slot_period_next  [MAX_TASKS];
    logic [TIME_W-1:0]   slot_release_next [MAX_TASKS];
    logic                slot_edf_next     [MAX_TASKS];
    logic [TIME_W-1:0]   slot_prio_next    [MAX_TASKS];
    logic [PEND_W-1:0]   slot_pend_next    [MAX_TASKS];

    ptrs_state_t         state_reg, state_next;
    ptrs_cmd_t           cur_reg, cur_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [TIME_W-1:0]   bound_reg, bound_next;
    logic [SLOT_W-1:0]   best_reg, best_next;
    logic                edf_seen_reg, edf_seen_next;
    logic                any_reg, any_next;
    logic [TIME_W-1:0]   rel_cnt_reg, rel_cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [TASK_W-1:0]   res_best_reg, res_best_next;
    logic                res_switch_reg, res_switch_next;
    logic                res_rel_reg, res_rel_next;
    logic [TIME_W-1:0]   res_total_reg, res_total_next;

    logic [SLOT_W-1:0]   wr_slot;
    logic                cand;

    assign wr_slot = SLOT_W'(qhead.cmd.task_index);
    assign cand    = slot_valid_reg[idx_reg] && (slot_pend_reg[idx_reg] != '0);

    always_comb
    begin
        slot_valid_next   = slot_valid_reg;
        slot_period_next  = slot_period_reg;
        slot_release_next = slot_release_reg;
        slot_edf_next     = slot_edf_reg;
        slot_prio_next    = slot_prio_reg;
        slot_pend_next    = slot_pend_reg;
        state_next        = state_reg;
        cur_next          = cur_reg;
        idx_next          = idx_reg;
        bound_next        = bound_reg;
        best_next         = best_reg;
        edf_seen_next     = edf_seen_reg;
        any_next          = any_reg;
        rel_cnt_next      = rel_cnt_reg;
        out_valid_next    = out_valid_reg && !sched_res.ready;
        res_best_next     = res_best_reg;
        res_switch_next   = res_switch_reg;
        res_rel_next      = res_rel_reg;
        res_total_next    = res_total_reg;
        pop               = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (qhead.valid)
                begin
                    pop           = 1'b1;
                    cur_next      = qhead.cmd;
                    idx_next      = SLOT_W'(1);
                    bound_next    = FP_PRIO_LIMIT;
                    best_next     = '0;
                    edf_seen_next = 1'b0;
                    any_next      = 1'b0;
                    case (qhead.cmd.op)
                        OP_WRITE:
                        begin
                            slot_valid_next[wr_slot]   = qhead.cmd.entry_valid;
                            slot_period_next[wr_slot]  = qhead.cmd.entry_period;
                            slot_release_next[wr_slot] = qhead.cmd.entry_release_time;
                            slot_edf_next[wr_slot]     = qhead.cmd.entry_is_edf;
                            slot_prio_next[wr_slot]    = qhead.cmd.entry_priority;
                            slot_pend_next[wr_slot]    = qhead.cmd.entry_pending;
                            state_next                 = ST_DONE;
                        end
                        OP_TICK, OP_SELECT: state_next = ST_SCAN;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cur_reg.op == OP_TICK)
                begin
                    if (slot_valid_reg[idx_reg] &&
                        cur_reg.now_time >= slot_release_reg[idx_reg])
                    begin
                        slot_release_next[idx_reg] = slot_release_reg[idx_reg] +
                                                     slot_period_reg[idx_reg];
                        if (slot_pend_reg[idx_reg] != PENDING_MAX)
                            slot_pend_next[idx_reg] = slot_pend_reg[idx_reg] + 1'b1;
                        rel_cnt_next = rel_cnt_reg + 1'b1;
                        any_next     = 1'b1;
                    end
                end
                else if (cand)
                begin
                    // EDF: ties go to the later slot; fixed priority: strict less
                    if (edf_seen_reg)
                    begin
                        if (slot_edf_reg[idx_reg] && slot_prio_reg[idx_reg] <= bound_reg)
                        begin
                            bound_next = slot_prio_reg[idx_reg];
                            best_next  = idx_reg;
                        end
                    end
                    else if (slot_edf_reg[idx_reg])
                    begin
                        edf_seen_next = 1'b1;
                        bound_next    = slot_prio_reg[idx_reg];
                        best_next     = idx_reg;
                    end
                    else if (slot_prio_reg[idx_reg] < bound_reg)
                    begin
                        bound_next = slot_prio_reg[idx_reg];
                        best_next  = idx_reg;
                    end
                end
                if (idx_reg == LAST_SLOT)
                    state_next = ST_DONE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || sched_res.ready)
                begin
                    out_valid_next  = 1'b1;
                    res_best_next   = (cur_reg.op == OP_SELECT) ? TASK_W'(best_reg) : '0;
                    res_switch_next = (cur_reg.op == OP_SELECT) &&
                                      (TASK_W'(best_reg) != cur_reg.current_task);
                    res_rel_next    = (cur_reg.op == OP_TICK) && any_reg;
                    res_total_next  = rel_cnt_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                slot_valid_reg[i]   <= 1'b0;
                slot_period_reg[i]  <= '0;
                slot_release_reg[i] <= '0;
                slot_edf_reg[i]     <= 1'b0;
                slot_prio_reg[i]    <= '0;
                slot_pend_reg[i]    <= '0;
            end
            state_reg     <= ST_IDLE;
            rel_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg   <= slot_valid_next;
            slot_period_reg  <= slot_period_next;
            slot_release_reg <= slot_release_next;
            slot_edf_reg     <= slot_edf_next;
            slot_prio_reg    <= slot_prio_next;
            slot_pend_reg    <= slot_pend_next;
            state_reg        <= state_next;
            rel_cnt_reg      <= rel_cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        idx_reg        <= idx_next;
        bound_reg      <= bound_next;
        best_reg       <= best_next;
        edf_seen_reg   <= edf_seen_next;
        any_reg        <= any_next;
        res_best_reg   <= res_best_next;
        res_switch_reg <= res_switch_next;
        res_rel_reg    <= res_rel_next;
        res_total_reg  <= res_total_next;
    end

    assign sched_res.valid         = out_valid_reg;
    assign sched_res.best_task     = res_best_reg;
    assign sched_res.switch_needed = res_switch_reg;
    assign sched_res.released_any  = res_rel_reg;
    assign sched_res.release_total = res_total_reg;

endmodule

### rtl/core/periodic_task_release_scheduler.sv
// ============================================================================
// periodic_task_release_scheduler: mixed EDF / fixed-priority task scheduler
// Task table with periodic release on tick and best-task selection on select.
// ============================================================================
// Usage:
//  - task_cmd (sink): one beat per command. command selects a table write,
//    a time tick (now_time) or a select (current_task). The entry_* fields
//    matter only for writes. A write to a slot beyond the table is dropped
//    but still answered; the spare command code changes nothing.
//  - sched_res (source): exactly one result beat per command beat, in order.
//    best_task/switch_needed are set by selects only, released_any by ticks
//    only; release_total always shows the running release count after the
//    command.
//  - A write or a spare command passes from the queue through ST_IDLE and
//    ST_DONE into the result register; a tick or a select also passes
//    through ST_SCAN, in which the scan engine visits slots 1..MAX_TASKS-1
//    one per cycle. The engine takes the next command only once it is idle.
//  - A two-deep command queue sits ahead of the engine, so commands are taken
//    while the engine works or while a result waits in the output register.
//    If the receiver stalls, the engine holds its finished result and the
//    queue fills; task_cmd.ready drops once it is full.
//  - Reset clears the whole table and the release counter at once; the block
//    takes commands in the first cycle after reset.
// ============================================================================
module periodic_task_release_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    ptrs_in_if.sink     task_cmd,
    ptrs_out_if.source  sched_res
);
    import ptrs_pkg::*;

    ptrs_qhead_t qhead;
    logic        pop;

    // intake: decode and queue
    ptrs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .task_cmd (task_cmd),
        .qhead    (qhead),
        .pop      (pop)
    );

    // execution: table, scans, result register
    ptrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qhead     (qhead),
        .pop       (pop),
        .sched_res (sched_res)
    );

    // engine never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> qhead.valid)
        else $error("pop from empty command queue");

    // a full queue cannot report empty
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        !task_cmd.ready |-> qhead.valid)
        else $error("queue full but head invalid");

    // a result carries tick info or select info, never both
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (sched_res.valid && sched_res.released_any) |->
            (sched_res.best_task == '0 && !sched_res.switch_needed))
        else $error("tick result carries select fields");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: periodic task release scheduler testbench
// Sends write / tick / select / spare commands over the command channel and
// checks every result beat against a cycle-free scheduler predictor kept in
// step with each accepted command. A directed table comes first, then random
// traffic in three idling phases.
// ============================================================================
module tb_top;

    import ptrs_pkg::*;

    // spare command code: no name for it in the package
    localparam logic [CMD_W-1:0] CMD_SPARE = CMD_W'(3);

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4 * (MAX_TASKS + 1);
    localparam int MAX_REPORTS  = 10;

    // one command beat, field for field as on the channel
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TASK_W-1:0] task_index;
        logic              entry_valid;
        logic [TIME_W-1:0] entry_period;
        logic [TIME_W-1:0] entry_release_time;
        logic              entry_is_edf;
        logic [TIME_W-1:0] entry_priority;
        logic [PEND_W-1:0] entry_pending;
        logic [TIME_W-1:0] now_time;
        logic [TASK_W-1:0] current_task;
    } sched_cmd_t;

    // one result beat
    typedef struct packed {
        logic [TASK_W-1:0] best_task;
        logic              switch_needed;
        logic              released_any;
        logic [TIME_W-1:0] release_total;
    } sched_res_t;

    // directed row: a command and, where pinned, its hand-typed answer
    typedef struct packed {
        sched_cmd_t cmd;
        logic       pinned;
        sched_res_t answer;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ptrs_in_if  cmd_if ();
    ptrs_out_if res_if ();

    periodic_task_release_scheduler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .task_cmd  (cmd_if),
        .sched_res (res_if)
    );

    // ------------------------------------------------------------------------
    // Clock: 2 ns period
    // ------------------------------------------------------------------------
    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted task table and release counter
    // ------------------------------------------------------------------------
    logic              slot_valid    [MAX_TASKS];
    logic [TIME_W-1:0] slot_period   [MAX_TASKS];
    logic [TIME_W-1:0] slot_next_rel [MAX_TASKS];
    logic              slot_edf      [MAX_TASKS];
    logic [TIME_W-1:0] slot_prio     [MAX_TASKS];
    logic [PEND_W-1:0] slot_pend     [MAX_TASKS];
    logic [TIME_W-1:0] release_cnt;

    sched_res_t sched_answers [$];      // answers still owed by the block
    int         mismatch_cnt;
    int         cycle_cnt;

    // idle percentages, changed per phase
    int src_idle_pct;
    int sink_idle_pct;

    // pinned answer travels with the beat currently on the channel
    logic       beat_pinned;
    sched_res_t beat_answer;

    // running wall clock, used to keep random ticks and release times close
    logic [TIME_W-1:0] wall_clock;

    initial
    begin
        for (int s = 0; s < MAX_TASKS; s++)
        begin
            slot_valid[s]    = 1'b0;
            slot_period[s]   = '0;
            slot_next_rel[s] = '0;
            slot_edf[s]      = 1'b0;
            slot_prio[s]     = '0;
            slot_pend[s]     = '0;
        end
        release_cnt  = '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        wall_clock   = '0;
    end

    // Applies one command to the predicted table and returns its result.
    function automatic sched_res_t run_scheduler_cmd(input sched_cmd_t c);
        sched_res_t        r;
        logic [TIME_W-1:0] bound;
        logic              edf_seen;
        logic [TASK_W-1:0] best;
        r        = '0;
        bound    = FP_PRIO_LIMIT;
        edf_seen = 1'b0;
        best     = '0;
        case (c.command)
            CMD_WRITE:
            begin
                if (int'(c.task_index) < MAX_TASKS)
                begin
                    slot_valid[c.task_index]    = c.entry_valid;
                    slot_period[c.task_index]   = c.entry_period;
                    slot_next_rel[c.task_index] = c.entry_release_time;
                    slot_edf[c.task_index]      = c.entry_is_edf;
                    slot_prio[c.task_index]     = c.entry_priority;
                    slot_pend[c.task_index]     = c.entry_pending;
                end
            end
            CMD_TICK:
            begin
                // slot 0 is the idle task and is never released
                for (int s = 1; s < MAX_TASKS; s++)
                begin
                    if (slot_valid[s] && c.now_time >= slot_next_rel[s])
                    begin
                        slot_next_rel[s] = slot_next_rel[s] + slot_period[s];
                        if (slot_pend[s] != PENDING_MAX)
                            slot_pend[s] = slot_pend[s] + 1'b1;
                        release_cnt    = release_cnt + 1'b1;
                        r.released_any = 1'b1;
                    end
                end
            end
            CMD_SELECT:
            begin
                // first EDF candidate resets the bound; after that only EDF
                // tasks compete and ties go to the later slot. Fixed-priority
                // tasks need strictly below the bound, so earlier slot wins.
                for (int s = 1; s < MAX_TASKS; s++)
                begin
                    if (slot_valid[s] && slot_pend[s] != '0)
                    begin
                        if (edf_seen)
                        begin
                            if (slot_edf[s] && slot_prio[s] <= bound)
                            begin
                                bound = slot_prio[s];
                                best  = TASK_W'(s);
                            end
                        end
                        else if (slot_edf[s])
                        begin
                            edf_seen = 1'b1;
                            bound    = slot_prio[s];
                            best     = TASK_W'(s);
                        end
                        else if (slot_prio[s] < bound)
                        begin
                            bound = slot_prio[s];
                            best  = TASK_W'(s);
                        end
                    end
                end
                r.best_task     = best;
                r.switch_needed = (best != c.current_task);
            end
            default: ;  // spare code leaves everything alone
        endcase
        r.release_total = release_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Command builders
    // ------------------------------------------------------------------------
    function automatic sched_cmd_t wr_cmd(input int idx, input logic v,
                                          input logic [TIME_W-1:0] per,
                                          input logic [TIME_W-1:0] rel,
                                          input logic edf,
                                          input logic [TIME_W-1:0] prio,
                                          input logic [PEND_W-1:0] pend);
        sched_cmd_t c;
        c                    = '0;
        c.command            = CMD_WRITE;
        c.task_index         = TASK_W'(idx);
        c.entry_valid        = v;
        c.entry_period       = per;
        c.entry_release_time = rel;
        c.entry_is_edf       = edf;
        c.entry_priority     = prio;
        c.entry_pending      = pend;
        return c;
    endfunction

    function automatic sched_cmd_t tick_cmd(input logic [TIME_W-1:0] now);
        sched_cmd_t c;
        c          = '0;
        c.command  = CMD_TICK;
        c.now_time = now;
        return c;
    endfunction

    function automatic sched_cmd_t sel_cmd(input int cur);
        sched_cmd_t c;
        c              = '0;
        c.command      = CMD_SELECT;
        c.current_task = TASK_W'(cur);
        return c;
    endfunction

    function automatic sched_res_t ans(input int best, input logic sw,
                                       input logic rel, input int total);
        sched_res_t r;
        r.best_task     = TASK_W'(best);
        r.switch_needed = sw;
        r.released_any  = rel;
        r.release_total = TIME_W'(total);
        return r;
    endfunction

    // Random command. Mostly well-formed traffic near the wall clock so that
    // ticks release and selects have real candidates; the rest is noise.
    function automatic sched_cmd_t draw_cmd();
        sched_cmd_t c;
        int         pick;
        int         r;
        // every field noisy first; the command then overrides what it uses
        c.task_index         = TASK_W'($urandom);
        c.entry_valid        = 1'($urandom_range(1));
        c.entry_period       = $urandom;
        c.entry_release_time = $urandom;
        c.entry_is_edf       = 1'($urandom_range(1));
        c.entry_priority     = $urandom;
        c.entry_pending      = PEND_W'($urandom);
        c.now_time           = $urandom;
        c.current_task       = TASK_W'($urandom);
        pick                 = $urandom_range(99);
        if (pick < 25)
        begin
            c.command = CMD_WRITE;
            if ($urandom_range(99) >= 20)
            begin
                c.entry_valid        = ($urandom_range(99) < 90);
                c.entry_period       = ($urandom_range(99) < 10) ? TIME_W'($urandom)
                                                                 : TIME_W'($urandom_range(12));
                c.entry_release_time = wall_clock + $urandom_range(10) - 2;
                c.entry_is_edf       = ($urandom_range(99) < 40);
                if (c.entry_is_edf)
                    c.entry_priority = $urandom_range(1) ? wall_clock + $urandom_range(30)
                                                         : TIME_W'($urandom_range(3));
                else if ($urandom_range(3) == 0)
                    c.entry_priority = TIME_W'($urandom_range(105, 95));
                else
                    c.entry_priority = TIME_W'($urandom_range(120));
                r = $urandom_range(99);
                if (r < 70)
                    c.entry_pending = '0;
                else if (r < 85)
                    c.entry_pending = PEND_W'($urandom_range(3, 1));
                else if (r < 93)
                    c.entry_pending = PENDING_MAX - PEND_W'($urandom_range(2));
            end
        end
        else if (pick < 60)
        begin
            c.command = CMD_TICK;
            if ($urandom_range(99) >= 5)
                c.now_time = wall_clock + $urandom_range(4);
            wall_clock = c.now_time;
        end
        else if (pick < 95)
            c.command = CMD_SELECT;
        else
            c.command = CMD_SPARE;
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Command driver: changes on the falling edge, holds until accepted
    // ------------------------------------------------------------------------
    task automatic push_cmd(input sched_cmd_t c, input logic pin, input sched_res_t a);
        while ($urandom_range(99) < src_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid              <= 1'b1;
        cmd_if.command            <= c.command;
        cmd_if.task_index         <= c.task_index;
        cmd_if.entry_valid        <= c.entry_valid;
        cmd_if.entry_period       <= c.entry_period;
        cmd_if.entry_release_time <= c.entry_release_time;
        cmd_if.entry_is_edf       <= c.entry_is_edf;
        cmd_if.entry_priority     <= c.entry_priority;
        cmd_if.entry_pending      <= c.entry_pending;
        cmd_if.now_time           <= c.now_time;
        cmd_if.current_task       <= c.current_task;
        beat_pinned               <= pin;
        beat_answer               <= a;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        @(negedge clk);
    endtask

    // result receiver: random back-pressure per phase
    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);

    // ------------------------------------------------------------------------
    // Monitor: predict on every accepted command, check every result beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_cmd_t seen;
        sched_res_t pred;
        sched_res_t want;
        sched_res_t got;
        if (rst_n && cmd_if.valid && cmd_if.ready)
        begin
            seen.command            = cmd_if.command;
            seen.task_index         = cmd_if.task_index;
            seen.entry_valid        = cmd_if.entry_valid;
            seen.entry_period       = cmd_if.entry_period;
            seen.entry_release_time = cmd_if.entry_release_time;
            seen.entry_is_edf       = cmd_if.entry_is_edf;
            seen.entry_priority     = cmd_if.entry_priority;
            seen.entry_pending      = cmd_if.entry_pending;
            seen.now_time           = cmd_if.now_time;
            seen.current_task       = cmd_if.current_task;
            pred = run_scheduler_cmd(seen);
            sched_answers.push_back(beat_pinned ? beat_answer : pred);
        end
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.best_task     = res_if.best_task;
            got.switch_needed = res_if.switch_needed;
            got.released_any  = res_if.released_any;
            got.release_total = res_if.release_total;
            if (sched_answers.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("[%0t] unexpected result beat: best=%0d sw=%0b rel=%0b total=%0d",
                             $realtime, got.best_task, got.switch_needed,
                             got.released_any, got.release_total);
            end
            else
            begin
                want = sched_answers.pop_front();
                if (got !== want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display({"[%0t] result mismatch: exp best=%0d sw=%0b rel=%0b ",
                                  "total=%0d / got best=%0d sw=%0b rel=%0b total=%0d"},
                                 $realtime, want.best_task, want.switch_needed,
                                 want.released_any, want.release_total,
                                 got.best_task, got.switch_needed,
                                 got.released_any, got.release_total);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        dir_row_t   dir_rows [$];
        sched_cmd_t spare;
        sched_res_t none;

        none = '0;

        rst_n                     = 1'b0;
        cmd_if.valid              = 1'b0;
        cmd_if.command            = CMD_WRITE;
        cmd_if.task_index         = '0;
        cmd_if.entry_valid        = 1'b0;
        cmd_if.entry_period       = '0;
        cmd_if.entry_release_time = '0;
        cmd_if.entry_is_edf       = 1'b0;
        cmd_if.entry_priority     = '0;
        cmd_if.entry_pending      = '0;
        cmd_if.now_time           = '0;
        cmd_if.current_task       = '0;
        res_if.ready              = 1'b0;
        beat_pinned               = 1'b0;
        beat_answer               = '0;
        src_idle_pct              = 33;
        sink_idle_pct             = 73;

        // spare code with every payload bit set: must change nothing
        spare              = wr_cmd(7, 1'b1, '1, '1, 1'b1, '1, '1);
        spare.command      = CMD_SPARE;
        spare.now_time     = '1;
        spare.current_task = '1;

        // empty table after reset: idle task, nothing released
        dir_rows.push_back('{sel_cmd(0), 1'b1, ans(0, 0, 0, 0)});
        dir_rows.push_back('{sel_cmd(7), 1'b1, ans(0, 1, 0, 0)});
        dir_rows.push_back('{tick_cmd('1), 1'b1, ans(0, 0, 0, 0)});
        dir_rows.push_back('{spare, 1'b1, ans(0, 0, 0, 0)});
        // idle slot loaded as a hot EDF task: never released, never picked
        dir_rows.push_back('{wr_cmd(0, 1, 0, 0, 1, 0, 5), 1'b1, ans(0, 0, 0, 0)});
        dir_rows.push_back('{tick_cmd('1), 1'b1, ans(0, 0, 0, 0)});
        dir_rows.push_back('{sel_cmd(0), 1'b1, ans(0, 0, 0, 0)});
        // priority exactly at the limit of 100 never qualifies
        dir_rows.push_back('{wr_cmd(1, 1, '1, 0, 0, 100, 0), 1'b1, ans(0, 0, 0, 0)});
        dir_rows.push_back('{tick_cmd(0), 1'b1, ans(0, 0, 1, 1)});
        dir_rows.push_back('{sel_cmd(1), 1'b1, ans(0, 1, 0, 1)});
        // fixed-priority at 99, then a tie: earlier slot keeps it
        dir_rows.push_back('{wr_cmd(2, 1, 0, '1, 0, 99, 1), 1'b1, ans(0, 0, 0, 1)});
        dir_rows.push_back('{sel_cmd(0), 1'b1, ans(2, 1, 0, 1)});
        dir_rows.push_back('{wr_cmd(3, 1, 0, '1, 0, 99, 1), 1'b1, ans(0, 0, 0, 1)});
        dir_rows.push_back('{sel_cmd(2), 1'b1, ans(2, 0, 0, 1)});
        // EDF with the latest deadline still beats any fixed priority
        dir_rows.push_back('{wr_cmd(5, 1, 0, '1, 1, '1, 1), 1'b1, ans(0, 0, 0, 1)});
        dir_rows.push_back('{sel_cmd(5), 1'b1, ans(5, 0, 0, 1)});
        // EDF tie: later slot wins; pending loaded at max
        dir_rows.push_back('{wr_cmd(6, 1, 1, '1, 1, '1, '1), 1'b1, ans(0, 0, 0, 1)});
        dir_rows.push_back('{sel_cmd(0), 1'b1, ans(6, 1, 0, 1)});
        // tick at max time: five slots release, pending saturates on slot 6,
        // next release wraps on slots 1 and 6
        dir_rows.push_back('{tick_cmd('1), 1'b1, ans(0, 0, 1, 6)});
        // invalid slot with an earlier deadline must not compete
        dir_rows.push_back('{wr_cmd(4, 0, 0, 0, 1, 0, 1), 1'b1, ans(0, 0, 0, 6)});
        dir_rows.push_back('{sel_cmd(6), 1'b1, ans(6, 0, 0, 6)});
        // from here on the predictor decides
        dir_rows.push_back('{wr_cmd(6, 1, 0, 0, 1, 0, 0), 1'b0, none});
        dir_rows.push_back('{sel_cmd(3), 1'b0, none});
        dir_rows.push_back('{wr_cmd(7, 1, '1, '1, 1, '1, '1), 1'b0, none});
        dir_rows.push_back('{sel_cmd(7), 1'b0, none});
        dir_rows.push_back('{tick_cmd(0), 1'b0, none});

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            push_cmd(dir_rows[i].cmd, dir_rows[i].pinned, dir_rows[i].answer);

        // random traffic: slow receiver, then slow sender, then no gaps
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 73 : 0;
            sink_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 33 : 0;
            repeat (phase == 2 ? 220 : 240)
                push_cmd(draw_cmd(), 1'b0, none);
        end
        cmd_if.valid <= 1'b0;

        // drain; the watchdog covers a block that stops answering
        while (sched_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
